[hw/rtl/tct_pkg.sv]
`default_nettype none

package tct_pkg;

    // Field widths
    localparam int SEQ_W    = 32;
    localparam int LEN_W    = 16;
    localparam int FLAGS_W  = 8;
    localparam int WIN_W    = 16;
    localparam int STATE_W  = 4;
    localparam int STATUS_W = 2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // TCP flag bit positions
    localparam int FLAG_FIN_BIT = 0;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_PSH_BIT = 3;
    localparam int FLAG_ACK_BIT = 4;

    // Exact flag bytes decoded on receive
    localparam logic [FLAGS_W-1:0] FLAGS_SYN         = 8'h02;
    localparam logic [FLAGS_W-1:0] FLAGS_SYN_ACK     = 8'h12;
    localparam logic [FLAGS_W-1:0] FLAGS_FIN         = 8'h01;
    localparam logic [FLAGS_W-1:0] FLAGS_FIN_ACK     = 8'h11;
    localparam logic [FLAGS_W-1:0] FLAGS_FIN_ACK_PSH = 8'h19;
    localparam logic [FLAGS_W-1:0] FLAGS_ACK         = 8'h10;
    localparam logic [FLAGS_W-1:0] FLAGS_ACK_PSH     = 8'h18;

    // Advertised windows
    localparam logic [WIN_W-1:0] WIN_WITH_ACK    = 16'd457;
    localparam logic [WIN_W-1:0] WIN_WITHOUT_ACK = 16'd14600;

    localparam logic MODE_RX = 1'b0;
    localparam logic MODE_TX = 1'b1;

    typedef enum logic [STATE_W-1:0] {
        ST_CLOSED      = 4'd0,
        ST_SYN_SENT    = 4'd1,
        ST_ESTABLISHED = 4'd2,
        ST_FIN_WAIT1   = 4'd3,
        ST_FIN_WAIT2   = 4'd4,
        ST_CLOSING     = 4'd5,
        ST_TIME_WAIT   = 4'd6,
        ST_CLOSE_WAIT  = 4'd7,
        ST_LAST_ACK    = 4'd8
    } t_conn_state;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_STATE = 2'd1,
        STS_BAD_FLAGS = 2'd2
    } t_status;

    // Segment classes handed from front to back
    typedef enum logic [2:0] {
        CMD_RX_SYN,
        CMD_RX_FIN,
        CMD_RX_FIN_DATA,
        CMD_RX_ACK_BARE,
        CMD_RX_ACK_DATA,
        CMD_RX_BAD,
        CMD_TX
    } t_cmd_kind;

    typedef struct packed {
        logic                mode;
        logic [FLAGS_W-1:0]  flags;
        logic [SEQ_W-1:0]    segment_seq;
        logic [LEN_W-1:0]    payload_len;
    } t_seg_in;

    typedef struct packed {
        logic [STATE_W-1:0]  conn_state;
        logic [SEQ_W-1:0]    hdr_seq;
        logic [SEQ_W-1:0]    hdr_ack;
        logic [WIN_W-1:0]    window_size;
        logic                send_ack;
        logic                deliver_payload;
        logic [STATUS_W-1:0] status;
    } t_seg_out;

    // Classified segment
    typedef struct packed {
        t_cmd_kind           kind;
        logic                fin_ack;
        logic                tx_syn;
        logic                tx_fin;
        logic                tx_psh;
        logic                tx_ack;
        logic [SEQ_W-1:0]    ack_cand;
        logic [LEN_W-1:0]    payload_len;
    } t_cmd;

endpackage

`default_nettype wire

[hw/rtl/tct_front.sv]
`default_nettype none

module tct_front
    import tct_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_seg_in i_in_data,
    output logic         o_cmd_valid,
    input  wire logic    i_cmd_ready,
    output t_cmd         o_cmd
);

    logic      r_valid;
    t_cmd      r_cmd;
    t_cmd      n_cmd;
    t_cmd_kind kind;
    logic      add_one;
    logic      load;

    // Flag decode on the exact flag byte
    always_comb begin
        kind = CMD_RX_BAD;
        if (i_in_data.mode == MODE_TX) begin
            kind = CMD_TX;
        end else if (i_in_data.flags == FLAGS_SYN || i_in_data.flags == FLAGS_SYN_ACK) begin
            kind = CMD_RX_SYN;
        end else if (i_in_data.flags == FLAGS_FIN || i_in_data.flags == FLAGS_FIN_ACK ||
                     i_in_data.flags == FLAGS_FIN_ACK_PSH) begin
            kind = (i_in_data.payload_len != '0) ? CMD_RX_FIN_DATA : CMD_RX_FIN;
        end else if (i_in_data.flags == FLAGS_ACK) begin
            kind = (i_in_data.payload_len != '0) ? CMD_RX_ACK_DATA : CMD_RX_ACK_BARE;
        end else if (i_in_data.flags == FLAGS_ACK_PSH) begin
            kind = CMD_RX_ACK_DATA;
        end
    end

    // Candidate ACK number: SYN and empty FIN count one, data counts its length
    assign add_one = (kind == CMD_RX_SYN) || (kind == CMD_RX_FIN);

    always_comb begin
        n_cmd             = '0;
        n_cmd.kind        = kind;
        n_cmd.fin_ack     = i_in_data.flags[FLAG_ACK_BIT];
        n_cmd.tx_syn      = i_in_data.flags[FLAG_SYN_BIT];
        n_cmd.tx_fin      = i_in_data.flags[FLAG_FIN_BIT];
        n_cmd.tx_psh      = i_in_data.flags[FLAG_PSH_BIT];
        n_cmd.tx_ack      = i_in_data.flags[FLAG_ACK_BIT];
        n_cmd.payload_len = i_in_data.payload_len;
        n_cmd.ack_cand    = i_in_data.segment_seq +
                            (add_one ? SEQ_W'(1) : SEQ_W'(i_in_data.payload_len));
    end

    // Stage register: refills whenever it is empty or drains into the queue
    assign load       = !r_valid || i_cmd_ready;
    assign o_in_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

`default_nettype wire

[hw/rtl/tct_queue.sv]
`default_nettype none

module tct_queue
    import tct_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_cmd i_push_cmd,
    output logic      o_pop_valid,
    input  wire logic i_pop,
    output t_cmd      o_pop_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tct_back.sv]
`default_nettype none

module tct_back
    import tct_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic [SEQ_W-1:0] i_cfg_data,
    input  wire logic             i_cmd_valid,
    output logic                  o_cmd_pop,
    input  wire t_cmd             i_cmd,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_seg_out              o_out_data
);

    t_conn_state      r_state;
    t_conn_state      n_state;
    logic [SEQ_W-1:0] r_send_seq;
    logic [SEQ_W-1:0] n_send_seq;
    logic [SEQ_W-1:0] r_ack_num;
    logic [SEQ_W-1:0] n_ack_num;
    logic [SEQ_W-1:0] r_init_seq;
    logic             r_out_valid;
    t_seg_out         r_out;
    t_seg_out         n_out;
    logic             exec;
    logic [SEQ_W-1:0] tx_base;
    t_conn_state      tx_state;

    // Execute when the output register is free or being taken
    assign exec      = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_cmd_pop = exec;

    // Next connection state, sequence numbers and result
    always_comb begin
        n_state    = r_state;
        n_send_seq = r_send_seq;
        n_ack_num  = r_ack_num;
        n_out      = '0;
        tx_base    = r_send_seq;
        tx_state   = r_state;

        unique case (i_cmd.kind)
            CMD_RX_SYN: begin
                n_ack_num        = i_cmd.ack_cand;
                n_out.send_ack   = 1'b1;
                if (r_state == ST_SYN_SENT) begin
                    n_state = ST_ESTABLISHED;
                end else begin
                    n_out.status = STS_BAD_STATE;
                end
            end
            CMD_RX_FIN: begin
                n_ack_num      = i_cmd.ack_cand;
                n_out.send_ack = 1'b1;
                unique case (r_state)
                    ST_FIN_WAIT1:   n_state = i_cmd.fin_ack ? ST_TIME_WAIT : ST_CLOSING;
                    ST_FIN_WAIT2:   n_state = ST_TIME_WAIT;
                    ST_ESTABLISHED: n_state = ST_CLOSE_WAIT;
                    default:        n_out.status = STS_BAD_STATE;
                endcase
            end
            CMD_RX_FIN_DATA, CMD_RX_ACK_DATA: begin
                n_ack_num             = i_cmd.ack_cand;
                n_out.send_ack        = 1'b1;
                n_out.deliver_payload = 1'b1;
            end
            CMD_RX_ACK_BARE: begin
                unique case (r_state)
                    ST_FIN_WAIT1: n_state = ST_FIN_WAIT2;
                    ST_CLOSING:   n_state = ST_TIME_WAIT;
                    ST_LAST_ACK:  n_state = ST_CLOSED;
                    default:      n_state = r_state;
                endcase
            end
            CMD_RX_BAD: begin
                n_out.status = STS_BAD_FLAGS;
            end
            CMD_TX: begin
                // SYN from closed opens the connection with the initial sequence
                if (i_cmd.tx_syn && r_state == ST_CLOSED) begin
                    tx_base  = r_init_seq;
                    tx_state = ST_SYN_SENT;
                end
                n_out.hdr_seq     = tx_base;
                n_out.hdr_ack     = r_ack_num;
                n_out.window_size = i_cmd.tx_ack ? WIN_WITH_ACK : WIN_WITHOUT_ACK;
                n_send_seq        = tx_base +
                                    (i_cmd.tx_psh ? SEQ_W'(i_cmd.payload_len) : '0) +
                                    SEQ_W'(i_cmd.tx_syn || i_cmd.tx_fin);
                n_state           = tx_state;
                if (i_cmd.tx_fin) begin
                    if (tx_state == ST_ESTABLISHED) begin
                        n_state = ST_FIN_WAIT1;
                    end else if (tx_state == ST_CLOSE_WAIT) begin
                        n_state = ST_LAST_ACK;
                    end
                end
            end
            default: begin
                n_out.status = STS_BAD_FLAGS;
            end
        endcase

        // A pure ACK going out carries the updated ACK number
        if (i_cmd.kind != CMD_TX && n_out.send_ack) begin
            n_out.hdr_seq     = r_send_seq;
            n_out.hdr_ack     = n_ack_num;
            n_out.window_size = WIN_WITH_ACK;
        end
        n_out.conn_state = n_state;
    end

    // Connection state and sequence registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLOSED;
            r_send_seq <= '0;
            r_ack_num  <= '0;
        end else if (exec) begin
            r_state    <= n_state;
            r_send_seq <= n_send_seq;
            r_ack_num  <= n_ack_num;
        end
    end

    // Initial sequence register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_seq <= '0;
        end else if (i_cfg_valid) begin
            r_init_seq <= i_cfg_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[hw/rtl/tcp_connection_tracker_unit.sv]
`default_nettype none

// TCP connection tracker. Takes one segment transaction per cycle unless
// stalled (received or transmitted, with flags, sequence number and payload
// length) and returns one result transaction per segment: the connection
// state after the segment, the header sequence/ACK numbers and window, whether
// a pure ACK must go out, whether the payload is delivered, and a status.
// Sustained rate is one segment per cycle when nothing stalls. The front stage
// decodes the flag byte and forms the candidate ACK number, a two-entry queue
// decouples it from the back stage, and the back stage updates state and send
// sequence, which is the loop that sets the rate. The initial sequence
// register is written through the configuration port (always ready); the
// user must write it only while the block is idle, which it does not enforce.

module tcp_connection_tracker_unit
    import tct_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [SEQ_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_seg_in          i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_seg_out              o_out_data
);

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    tct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    tct_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_cmd    (q_cmd)
    );

    tct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
